FILE: src/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg: shared types and constants for the aging priority arbiter
// Register map codes, APB widths, bypass counter limits and reset values.
// ----------------------------------------------------------------------------
package pra_pkg;

    // APB register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register word index (byte address / 4)
    typedef logic [APB_ADDR_W-3:0] t_reg_idx;
    localparam t_reg_idx REG_INIT_PRIO = 1'b0;
    localparam t_reg_idx REG_AGING_THR = 1'b1;

    // Bypass counter
    localparam int CNT_W = 4;
    typedef logic [CNT_W-1:0] t_count;
    localparam t_count CNT_MAX   = 4'd15;
    localparam t_count THR_RESET = 4'd2;

    // Priority floor for aging and the per-requester reset priority
    localparam int PRIO_FLOOR = 1;
    localparam int PRIO_RESET = 1;

    // Width of the zero-extended write word that initial priorities are cut from
    localparam int INIT_SRC_W = 64;

endpackage

FILE: src/pra_cfg_regs.sv
// ----------------------------------------------------------------------------
// pra_cfg_regs: APB configuration registers
// Holds the initial priorities and the aging threshold; always ready.
// ----------------------------------------------------------------------------
module pra_cfg_regs
    import pra_pkg::*;
#(
    parameter int NUM_REQUESTERS = 8,
    parameter int PRIORITY_BITS  = 3
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [APB_ADDR_W-1:0]                          paddr,
    input  logic [APB_DATA_W-1:0]                          pwdata,
    output logic [APB_DATA_W-1:0]                          prdata,
    output logic                                           pready,
    output logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0]   o_init_prio,
    output t_count                                         o_threshold
);

    logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0] r_init_prio;
    logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0] n_init_prio;
    t_count                                       r_threshold;
    t_reg_idx                                     reg_idx;
    logic                                         wr_en;
    logic [INIT_SRC_W-1:0]                        wr_word;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_word = INIT_SRC_W'(pwdata);

    // Slice the write word into priority fields; fields past the word read as zero
    for (genvar g = 0; g < NUM_REQUESTERS; g++) begin : g_unpack
        if ((g + 1) * PRIORITY_BITS <= INIT_SRC_W) begin : g_in
            assign n_init_prio[g] = wr_word[g*PRIORITY_BITS +: PRIORITY_BITS];
        end else begin : g_out
            assign n_init_prio[g] = '0;
        end
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REQUESTERS; i++) begin
                r_init_prio[i] <= PRIORITY_BITS'(PRIO_RESET);
            end
            r_threshold <= THR_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_INIT_PRIO: r_init_prio <= n_init_prio;
                REG_AGING_THR: r_threshold <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_INIT_PRIO: prdata = APB_DATA_W'(r_init_prio);
            REG_AGING_THR: prdata = APB_DATA_W'(r_threshold);
            default:       prdata = '0;
        endcase
    end

    assign o_init_prio = r_init_prio;
    assign o_threshold = r_threshold;

endmodule

FILE: src/pra_core.sv
// ----------------------------------------------------------------------------
// pra_core: aging, grant selection and bypass counting
// Holds current priorities and bypass counts; one arbitration per fire.
// ----------------------------------------------------------------------------
module pra_core
    import pra_pkg::*;
#(
    parameter int NUM_REQUESTERS = 8,
    parameter int PRIORITY_BITS  = 3,
    localparam int IDX_W         = $clog2(NUM_REQUESTERS)
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_fire,
    input  logic [NUM_REQUESTERS-1:0]                      i_waiting,
    input  logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0]   i_init_prio,
    input  t_count                                         i_threshold,
    output logic                                           o_grant_valid,
    output logic [IDX_W-1:0]                               o_grant_index,
    output logic [PRIORITY_BITS-1:0]                       o_grant_prio,
    output logic [NUM_REQUESTERS-1:0]                      o_aged_mask
);

    logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0] r_cur_prio;
    logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0] n_cur_prio;
    t_count                                       r_count [NUM_REQUESTERS];
    t_count                                       n_count [NUM_REQUESTERS];
    logic [NUM_REQUESTERS-1:0]                    aged;
    logic [NUM_REQUESTERS-1:0]                    win_oh;
    logic                                         found;
    logic [IDX_W-1:0]                             win_idx;
    logic [PRIORITY_BITS-1:0]                     win_prio;
    logic [PRIORITY_BITS-1:0]                     win_init;

    // Age waiting requesters whose count reached the threshold
    always_comb begin
        for (int i = 0; i < NUM_REQUESTERS; i++) begin
            aged[i] = i_waiting[i] && (r_count[i] >= i_threshold);
            if (aged[i] && (r_cur_prio[i] > PRIORITY_BITS'(PRIO_FLOOR))) begin
                n_cur_prio[i] = r_cur_prio[i] - PRIORITY_BITS'(1);
            end else begin
                n_cur_prio[i] = r_cur_prio[i];
            end
        end
    end

    // Pick the most urgent waiting requester; lowest index breaks ties
    always_comb begin
        for (int i = 0; i < NUM_REQUESTERS; i++) begin
            win_oh[i] = i_waiting[i];
            for (int j = 0; j < NUM_REQUESTERS; j++) begin
                if (j != i && i_waiting[j] &&
                    ((n_cur_prio[j] < n_cur_prio[i]) ||
                     ((n_cur_prio[j] == n_cur_prio[i]) && (j < i)))) begin
                    win_oh[i] = 1'b0;
                end
            end
        end
    end

    assign found = |i_waiting;

    // Encode the winner
    always_comb begin
        win_idx  = '0;
        win_prio = '0;
        win_init = '0;
        for (int i = 0; i < NUM_REQUESTERS; i++) begin
            if (win_oh[i]) begin
                win_idx  = win_idx | IDX_W'(i);
                win_prio = win_prio | n_cur_prio[i];
                win_init = win_init | i_init_prio[i];
            end
        end
    end

    // Clear aged counts, then bump bypassed requesters of lower initial urgency
    always_comb begin
        for (int i = 0; i < NUM_REQUESTERS; i++) begin
            n_count[i] = aged[i] ? '0 : r_count[i];
            if (found && i_waiting[i] && !win_oh[i] &&
                (i_init_prio[i] > win_init) && (n_count[i] != CNT_MAX)) begin
                n_count[i] = n_count[i] + t_count'(1);
            end
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REQUESTERS; i++) begin
                r_cur_prio[i] <= PRIORITY_BITS'(PRIO_RESET);
                r_count[i]    <= '0;
            end
        end else if (i_fire) begin
            r_cur_prio <= n_cur_prio;
            for (int i = 0; i < NUM_REQUESTERS; i++) begin
                r_count[i] <= n_count[i];
            end
        end
    end

    assign o_grant_valid = found;
    assign o_grant_index = win_idx;
    assign o_grant_prio  = win_prio;
    assign o_aged_mask   = aged;

endmodule

FILE: src/priority_arbiter_with_aging_top.sv
// ----------------------------------------------------------------------------
// priority_arbiter_with_aging_top: static priority arbiter with aging
// Usage:
//   Slave stream: each beat carries the mask of waiting requesters. The block
//   ages starved requesters, grants the most urgent one (lowest index on a
//   tie) and counts bypasses for the rest.
//   Master stream: one beat per input beat with grant valid, grant index,
//   granted priority and the mask of requesters aged in that step.
//   APB port: initial priorities (address 0) and aging threshold (address 4);
//   write only while no beat is in flight.
// Timing:
//   An input beat is registered in the input register at acceptance and its
//   result in the result register, which drives the master stream, once that
//   register is free. One beat per cycle is sustained while the master side
//   takes beats; aging, the compare matrix and winner encode sit in between.
//   When the master side stalls, the result register holds and one more input
//   beat is taken into the input register before tready drops.
// Reset:
//   Both registers empty, current priorities at 1, bypass counts at zero,
//   initial priorities at 1 and aging threshold at 2.
// ----------------------------------------------------------------------------
module priority_arbiter_with_aging_top
    import pra_pkg::*;
#(
    parameter int NUM_REQUESTERS = 8,
    parameter int PRIORITY_BITS  = 3,
    localparam int IDX_W         = $clog2(NUM_REQUESTERS),
    localparam int IN_TDATA_W    = ((NUM_REQUESTERS + 7) / 8) * 8,
    localparam int OUT_BITS      = 1 + IDX_W + PRIORITY_BITS + NUM_REQUESTERS,
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // waiting_mask
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,
    // grant_valid, grant_index, grant_priority, aged_mask
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_tdata,
    // APB configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0] init_prio;
    t_count                                       threshold;
    logic                                         r_s1_valid;
    logic [NUM_REQUESTERS-1:0]                    r_s1_mask;
    logic                                         r_m_valid;
    logic [OUT_TDATA_W-1:0]                       r_m_data;
    logic [OUT_TDATA_W-1:0]                       n_m_data;
    logic                                         s1_adv;
    logic                                         in_beat;
    logic                                         grant_valid;
    logic [IDX_W-1:0]                             grant_index;
    logic [PRIORITY_BITS-1:0]                     grant_prio;
    logic [NUM_REQUESTERS-1:0]                    aged_mask;

    pra_cfg_regs #(
        .NUM_REQUESTERS (NUM_REQUESTERS),
        .PRIORITY_BITS  (PRIORITY_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_init_prio (init_prio),
        .o_threshold (threshold)
    );

    // Advance the input register into the result register when it is free
    assign s1_adv     = r_s1_valid && (!r_m_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign in_beat    = i_s_tvalid && o_s_tready;

    pra_core #(
        .NUM_REQUESTERS (NUM_REQUESTERS),
        .PRIORITY_BITS  (PRIORITY_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (s1_adv),
        .i_waiting     (r_s1_mask),
        .i_init_prio   (init_prio),
        .i_threshold   (threshold),
        .o_grant_valid (grant_valid),
        .o_grant_index (grant_index),
        .o_grant_prio  (grant_prio),
        .o_aged_mask   (aged_mask)
    );

    assign n_m_data = OUT_TDATA_W'({aged_mask, grant_prio, grant_index, grant_valid});

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_mask <= i_s_tdata[NUM_REQUESTERS-1:0];
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_adv) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

FILE: src/pra_checker.sv
// ----------------------------------------------------------------------------
// pra_checker: port-level checks for the aging priority arbiter
// Watches the result stream and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module pra_checker
    import pra_pkg::*;
#(
    parameter int NUM_REQUESTERS = 8,
    parameter int PRIORITY_BITS  = 3,
    localparam int IDX_W         = $clog2(NUM_REQUESTERS),
    localparam int OUT_BITS      = 1 + IDX_W + PRIORITY_BITS + NUM_REQUESTERS,
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8,
    localparam int PRIO_LSB      = 1 + IDX_W,
    localparam int AGED_LSB      = 1 + IDX_W + PRIORITY_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_m_tready,
    input  logic                    o_m_tvalid,
    input  logic [OUT_TDATA_W-1:0]  o_m_tdata
);

    logic                      grant_valid;
    logic [IDX_W-1:0]          grant_index;
    logic [PRIORITY_BITS-1:0]  grant_prio;
    logic [NUM_REQUESTERS-1:0] aged_mask;

    assign grant_valid = o_m_tdata[0];
    assign grant_index = o_m_tdata[IDX_W:1];
    assign grant_prio  = o_m_tdata[PRIO_LSB +: PRIORITY_BITS];
    assign aged_mask   = o_m_tdata[AGED_LSB +: NUM_REQUESTERS];

    // No result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result beat shown right after reset");

    // An empty step grants nothing and ages nothing
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !grant_valid) |->
            (grant_index == '0 && grant_prio == '0 && aged_mask == '0))
        else $error("empty step carries a grant or aging");

    // The granted priority never drops below the floor
    a_prio_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && grant_valid) |-> (grant_prio != '0))
        else $error("granted priority below floor");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind priority_arbiter_with_aging_top pra_checker #(
    .NUM_REQUESTERS (NUM_REQUESTERS),
    .PRIORITY_BITS  (PRIORITY_BITS)
) u_pra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata)
);

FILE: bench/tb_priority_arbiter_with_aging_top.sv
// ----------------------------------------------------------------------------
// tb_priority_arbiter_with_aging_top: self-checking bench for the aging arbiter
// Drives waiting masks on the slave stream and predicts every grant beat from
// a behavioral copy of the arbiter state: current priorities, bypass counts,
// initial priorities and aging threshold. Grant beats are checked field by
// field in order. Covers directed corner cases, a sweep of register settings
// with random traffic, a long master-side hold and a drained sender pause.
// ----------------------------------------------------------------------------
module tb_priority_arbiter_with_aging_top;
    import pra_pkg::*;

    localparam int NREQ        = 8;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic [2:0] level;
        logic [7:0] aged;
    } t_grant;

    // DUT signals; the driven inputs are all known from time zero
    logic                  i_clk    = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [15:0]           m_tdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    // Predicted arbiter state
    logic [2:0] cur_prio [NREQ];
    logic [3:0] byp_cnt  [NREQ];
    logic [2:0] init_prio[NREQ];
    logic [3:0] age_thr;

    t_grant expected_grants[$];
    t_grant want;
    int     mismatch_count = 0;

    // Traffic shaping knobs, percent chance per item or per cycle
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int rx_hold_req   = 0;
    int rx_stall_left = 0;

    priority_arbiter_with_aging_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [7:0] waiting_mask
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [0] valid, [3:1] index, [6:4] priority, [14:7] aged
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("tb_priority_arbiter_with_aging_top failed");
        $finish;
    end

    // Gap length: mostly short, now and then long
    function automatic int pick_gap_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(16, 60);
        return $urandom_range(1, 3);
    endfunction

    // Age, grant and count bypasses for one waiting mask
    function automatic t_grant arbitrate(input logic [7:0] waiting);
        t_grant     g;
        bit         found;
        int         win;
        logic [2:0] best;
        g     = '0;
        found = 1'b0;
        win   = 0;
        best  = '0;
        for (int i = 0; i < NREQ; i++) begin
            if (waiting[i] && byp_cnt[i] >= age_thr) begin
                if (cur_prio[i] > PRIO_FLOOR)
                    cur_prio[i] = cur_prio[i] - 3'd1;
                byp_cnt[i] = '0;
                g.aged[i]  = 1'b1;
            end
        end
        for (int i = 0; i < NREQ; i++) begin
            if (waiting[i] && (!found || cur_prio[i] < best)) begin
                found = 1'b1;
                best  = cur_prio[i];
                win   = i;
            end
        end
        if (found) begin
            for (int i = 0; i < NREQ; i++) begin
                if (waiting[i] && i != win && init_prio[i] > init_prio[win] &&
                        byp_cnt[i] < CNT_MAX)
                    byp_cnt[i] = byp_cnt[i] + 4'd1;
            end
            g.valid = 1'b1;
            g.index = 3'(win);
            g.level = best;
        end
        return g;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Check every grant beat against the oldest prediction
    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected grant beat, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_grants.pop_front();
                check_field("grant_valid",    want.valid, m_tdata[0]);
                check_field("grant_index",    want.index, m_tdata[3:1]);
                check_field("grant_priority", want.level, m_tdata[6:4]);
                check_field("aged_mask",      want.aged,  m_tdata[14:7]);
            end
        end
    end

    // Master-side ready: random stalls, or a long hold when requested
    always @(posedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_stall_left = rx_hold_req;
            rx_hold_req   = 0;
        end else if (rx_stall_left == 0 && $urandom_range(99) < rx_stall_pct) begin
            rx_stall_left = pick_gap_len();
        end
        if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic reset_predictor();
        for (int i = 0; i < NREQ; i++) begin
            cur_prio[i]  = 3'(PRIO_RESET);
            init_prio[i] = 3'(PRIO_RESET);
            byp_cnt[i]   = '0;
        end
        age_thr = THR_RESET;
    endtask

    // Offer one waiting mask; predict its grant at the accepting edge
    task automatic offer_waiting(input logic [7:0] mask, output t_grant g);
        int gap;
        gap = ($urandom_range(99) < tx_gap_pct) ? pick_gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mask;
        do @(posedge i_clk); while (!s_tready);
        g = arbitrate(mask);
        expected_grants.push_back(g);
    endtask

    // Drop valid and wait until every predicted grant has come out
    task automatic quiesce();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_grants.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_grants.size() != 0) begin
            $display("%0t: grant beats missing, expected %0d more, actual 0",
                     $time, expected_grants.size());
            mismatch_count += expected_grants.size();
            expected_grants.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup, then access; mirror into the predictor
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INIT_PRIO: begin
                for (int i = 0; i < NREQ; i++)
                    init_prio[i] = value[3*i +: 3];
            end
            REG_AGING_THR: age_thr = value[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_list(input logic [7:0] masks[$]);
        t_grant g;
        foreach (masks[k])
            offer_waiting(masks[k], g);
    endtask

    // Reset defaults: empty mask, full mask, edge requesters
    task automatic test_reset_defaults();
        tx_gap_pct   = 30;
        rx_stall_pct = 10;
        send_list('{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hAA, 8'h55});
        quiesce();
    endtask

    // Requester 0 at priority 0, the rest at 7; aging holds at the floor
    task automatic test_floor_aging();
        write_reg(REG_INIT_PRIO, 32'h00FF_FFF8);
        write_reg(REG_AGING_THR, 32'd1);
        send_list('{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 8'h00});
        quiesce();
    endtask

    // Threshold zero ages every waiting requester on every beat
    task automatic test_threshold_zero();
        write_reg(REG_AGING_THR, 32'd0);
        send_list('{8'hFF, 8'h81, 8'h00, 8'h10});
        quiesce();
    endtask

    // Rewrite initial priorities: only bypass counting follows
    task automatic test_prio_rewrite();
        write_reg(REG_INIT_PRIO, 32'h00FA_C688);
        write_reg(REG_AGING_THR, 32'd2);
        send_list('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        quiesce();
    endtask

    // Random traffic, mostly starved requesters that keep waiting
    task automatic run_traffic(input int n_items);
        logic [7:0] pending;
        logic [7:0] mask;
        t_grant     g;
        pending = 8'($urandom);
        repeat (n_items) begin
            if ($urandom_range(9) < 7) begin
                pending = pending | (8'($urandom) & 8'($urandom));
                mask    = pending;
            end else begin
                case ($urandom_range(3))
                    0:       mask = 8'h00;
                    1:       mask = 8'hFF;
                    default: mask = 8'($urandom);
                endcase
            end
            offer_waiting(mask, g);
            if (g.valid)
                pending[g.index] = 1'b0;
        end
    endtask

    // Sweep register settings, extremes first, with varied idling
    task automatic test_config_sweep();
        logic [31:0] init_v;
        logic [31:0] thr_v;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0:       begin init_v = 32'h0000_0000; thr_v = 32'd1;  end
                1:       begin init_v = 32'hFFFF_FFFF; thr_v = 32'd15; end
                2:       begin init_v = 32'h00FA_C688; thr_v = 32'd0;  end
                3:       begin init_v = 32'h0000_0007; thr_v = 32'd15; end
                default: begin init_v = $urandom;      thr_v = $urandom; end
            endcase
            write_reg(REG_INIT_PRIO, init_v);
            write_reg(REG_AGING_THR, thr_v);
            case (ph)
                0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_gap_pct = 50; rx_stall_pct = 30; end
                default: begin
                    tx_gap_pct   = $urandom_range(40);
                    rx_stall_pct = $urandom_range(25);
                end
            endcase
            run_traffic(150);
            quiesce();
        end
    endtask

    // Hold the master side while the sender keeps offering beats
    task automatic test_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        write_reg(REG_INIT_PRIO, $urandom);
        write_reg(REG_AGING_THR, 32'd3);
        rx_hold_req = 200;
        run_traffic(60);
        quiesce();
    endtask

    // Pause the sender until all grants are out, then resume
    task automatic test_sender_pause();
        tx_gap_pct   = 20;
        rx_stall_pct = 15;
        run_traffic(40);
        quiesce();
        run_traffic(40);
        quiesce();
    endtask

    initial begin
        reset_predictor();
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_floor_aging();
        test_threshold_zero();
        test_prio_rewrite();
        test_config_sweep();
        test_backpressure();
        test_sender_pause();
        quiesce();
        if (mismatch_count == 0) begin
            $display("tb_priority_arbiter_with_aging_top passed");
        end else begin
            $display("tb_priority_arbiter_with_aging_top failed");
        end
        $finish;
    end

endmodule
